### rtl/cbqn_pkg.sv
package cbqn_pkg;

   localparam int SECTIONS     = 3;
   localparam int SAMPLE_WIDTH = 16;
   localparam int HIST_WIDTH   = SAMPLE_WIDTH + 8;
   localparam int COEF_WIDTH   = 18;
   localparam int COEF_FRAC    = 14;
   localparam int CFG_SECTIONS = 3;
   localparam int CSR_IDX_W    = 3;

   localparam int PROD_WIDTH   = COEF_WIDTH + HIST_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + 3;
   localparam int SHIFT_WIDTH  = ACC_WIDTH + 1 - COEF_FRAC;
   localparam int SEC_W        = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int STEP_W       = 3;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic signed [HIST_WIDTH-1:0] hist_word_type;

   localparam coef_type COEF_ONE = COEF_WIDTH'(2 ** COEF_FRAC);
   localparam logic signed [ACC_WIDTH:0] ROUND_HALF = (ACC_WIDTH + 1)'(2 ** (COEF_FRAC - 1));

   localparam coef_type RESET_MID [CFG_SECTIONS] =
      '{COEF_WIDTH'(-29196), COEF_WIDTH'(-23170), COEF_WIDTH'(-14876)};
   localparam coef_type RESET_POLE [CFG_SECTIONS] =
      '{COEF_WIDTH'(-27736), COEF_WIDTH'(-22012), COEF_WIDTH'(-14133)};
   localparam coef_type RESET_RADIUS = COEF_WIDTH'(14787);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_S1_MID    = 3'd0,
      CSR_S1_POLE   = 3'd1,
      CSR_S2_MID    = 3'd2,
      CSR_S2_POLE   = 3'd3,
      CSR_S3_MID    = 3'd4,
      CSR_S3_POLE   = 3'd5,
      CSR_RADIUS    = 3'd6
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [1:0] {
      COEF_SEL_ONE,
      COEF_SEL_MID,
      COEF_SEL_POLE,
      COEF_SEL_RADIUS
   } coef_sel_type;

   typedef enum logic [2:0] {
      OPND_X,
      OPND_X0,
      OPND_X1,
      OPND_Y0,
      OPND_Y1
   } opnd_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_SECTION,
      BR_DONE
   } branch_type;

   typedef struct packed {
      coef_sel_type coef_sel;
      opnd_sel_type opnd_sel;
      logic         neg;
      acc_op_type   acc_op;
      branch_type   branch;
   } ctrl_word_type;

   typedef struct packed {
      hist_word_type x0;
      hist_word_type x1;
      hist_word_type y0;
      hist_word_type y1;
   } hist_type;

   // Microprogram for one section: five products through the shared multiplier,
   // a drain step for the product register, write back, and the final output step.
   function automatic ctrl_word_type prog_word(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '{COEF_SEL_ONE, OPND_X, 1'b0, ACC_HOLD, BR_NEXT};
      case (step)
         3'd0: cw = '{COEF_SEL_ONE,    OPND_X,  1'b0, ACC_HOLD, BR_NEXT};
         3'd1: cw = '{COEF_SEL_MID,    OPND_X0, 1'b0, ACC_LOAD, BR_NEXT};
         3'd2: cw = '{COEF_SEL_ONE,    OPND_X1, 1'b0, ACC_ADD,  BR_NEXT};
         3'd3: cw = '{COEF_SEL_POLE,   OPND_Y0, 1'b1, ACC_ADD,  BR_NEXT};
         3'd4: cw = '{COEF_SEL_RADIUS, OPND_Y1, 1'b1, ACC_ADD,  BR_NEXT};
         3'd5: cw = '{COEF_SEL_ONE,    OPND_X,  1'b0, ACC_ADD,  BR_NEXT};
         3'd6: cw = '{COEF_SEL_ONE,    OPND_X,  1'b0, ACC_HOLD, BR_SECTION};
         3'd7: cw = '{COEF_SEL_ONE,    OPND_X,  1'b0, ACC_HOLD, BR_DONE};
         default: cw = '{COEF_SEL_ONE, OPND_X,  1'b0, ACC_HOLD, BR_DONE};
      endcase
      return cw;
   endfunction

endpackage

### rtl/cascaded_biquad_notch_filter.sv
// Three cascaded direct-form-I biquad notch sections on signed Q1.15 samples,
// y = x + b1*x1 + x2 - a1*y1 - a2*y2 per section, each section output rounded
// and saturated to 24 bits, final output saturated to 16 bits. Coefficients
// are Q4.14 registers written through the csr_ port (index 0..6, others ignored);
// write them only while no item is in flight. A single multiplier is driven by a
// small microprogram, seven steps per section plus one output step. A new item is
// accepted only while the sequencer is idle, not while one is in flight. A finished
// result waits in an output register, so the next item can already be accepted; only
// a second result meeting a still-held first one stalls the sequencer.
module cascaded_biquad_notch_filter
   import cbqn_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [COEF_WIDTH-1:0]          csr_data
);

   seq_state_type                  state_ff, state_in;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic [SEC_W-1:0]               sec_ff, sec_in;
   hist_word_type                  x_ff, x_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic                           neg_ff, neg_in;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   hist_type                       hist_ff [SECTIONS];
   hist_type                       hist_in [SECTIONS];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_ff, rsp_filtered_in;

   coef_type                       mid_ff [CFG_SECTIONS];
   coef_type                       pole_ff [CFG_SECTIONS];
   coef_type                       radius_ff;

   ctrl_word_type                  cw;
   coef_type                       mid_tap;
   coef_type                       pole_tap;
   coef_type                       coef_val;
   hist_word_type                  opnd_val;
   logic signed [ACC_WIDTH-1:0]    prod_ext;
   logic signed [ACC_WIDTH:0]      rounded;
   logic signed [SHIFT_WIDTH-1:0]  shifted;
   hist_word_type                  sec_out;
   logic signed [SAMPLE_WIDTH-1:0] final_out;
   hist_type                       head_new;

   assign cw = prog_word(step_ff);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // Coefficients of the active section; sections past the configured ones use zero.
   always_comb begin
      mid_tap  = '0;
      pole_tap = '0;
      for (int i = 0; i < CFG_SECTIONS; i++) begin
         if (int'(sec_ff) == i) begin
            mid_tap  = mid_ff[i];
            pole_tap = pole_ff[i];
         end
      end
   end

   always_comb begin
      case (cw.coef_sel)
         COEF_SEL_ONE:    coef_val = COEF_ONE;
         COEF_SEL_MID:    coef_val = mid_tap;
         COEF_SEL_POLE:   coef_val = pole_tap;
         COEF_SEL_RADIUS: coef_val = radius_ff;
         default:         coef_val = COEF_ONE;
      endcase
      case (cw.opnd_sel)
         OPND_X:  opnd_val = x_ff;
         OPND_X0: opnd_val = hist_ff[0].x0;
         OPND_X1: opnd_val = hist_ff[0].x1;
         OPND_Y0: opnd_val = hist_ff[0].y0;
         OPND_Y1: opnd_val = hist_ff[0].y1;
         default: opnd_val = x_ff;
      endcase
   end

   assign prod_in  = coef_val * opnd_val;
   assign neg_in   = cw.neg;
   assign prod_ext = ACC_WIDTH'(prod_ff);

   // Round half up, then saturate to the history width.
   assign rounded = (ACC_WIDTH + 1)'(acc_ff) + ROUND_HALF;
   assign shifted = rounded[ACC_WIDTH:COEF_FRAC];

   always_comb begin
      if ((&shifted[SHIFT_WIDTH-1:HIST_WIDTH-1]) || !(|shifted[SHIFT_WIDTH-1:HIST_WIDTH-1])) begin
         sec_out = shifted[HIST_WIDTH-1:0];
      end else begin
         sec_out = {shifted[SHIFT_WIDTH-1], {(HIST_WIDTH-1){~shifted[SHIFT_WIDTH-1]}}};
      end
      if ((&x_ff[HIST_WIDTH-1:SAMPLE_WIDTH-1]) || !(|x_ff[HIST_WIDTH-1:SAMPLE_WIDTH-1])) begin
         final_out = x_ff[SAMPLE_WIDTH-1:0];
      end else begin
         final_out = {x_ff[HIST_WIDTH-1], {(SAMPLE_WIDTH-1){~x_ff[HIST_WIDTH-1]}}};
      end
   end

   assign head_new = '{x0: x_ff, x1: hist_ff[0].x0, y0: sec_out, y1: hist_ff[0].y0};

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      sec_in          = sec_ff;
      x_in            = x_ff;
      acc_in          = acc_ff;
      hist_in         = hist_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_filtered_in = rsp_filtered_ff;
      req_ready       = (state_ff == SEQ_IDLE);

      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               x_in     = HIST_WIDTH'(req_sample);
               step_in  = '0;
               sec_in   = '0;
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            case (cw.acc_op)
               ACC_LOAD: acc_in = prod_ext;
               ACC_ADD:  acc_in = neg_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
               default:  acc_in = acc_ff;
            endcase
            case (cw.branch)
               BR_NEXT: begin
                  step_in = step_ff + 1'b1;
               end
               BR_SECTION: begin
                  // rotate so the next section's history sits at the head
                  for (int i = 0; i < SECTIONS - 1; i++) begin
                     hist_in[i] = hist_ff[i+1];
                  end
                  hist_in[SECTIONS-1] = head_new;
                  x_in = sec_out;
                  if (int'(sec_ff) == SECTIONS - 1) begin
                     sec_in  = '0;
                     step_in = step_ff + 1'b1;
                  end else begin
                     sec_in  = sec_ff + 1'b1;
                     step_in = '0;
                  end
               end
               BR_DONE: begin
                  // hold until the output register is free
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_in    = 1'b1;
                     rsp_filtered_in = final_out;
                     state_in        = SEQ_IDLE;
                  end
               end
               default: begin
                  state_in = SEQ_IDLE;
               end
            endcase
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         step_ff      <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SECTIONS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      prod_ff         <= prod_in;
      neg_ff          <= neg_in;
      acc_ff          <= acc_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_SECTIONS; i++) begin
            mid_ff[i]  <= RESET_MID[i];
            pole_ff[i] <= RESET_POLE[i];
         end
         radius_ff <= RESET_RADIUS;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_S1_MID:  mid_ff[0]  <= csr_data;
            CSR_S1_POLE: pole_ff[0] <= csr_data;
            CSR_S2_MID:  mid_ff[1]  <= csr_data;
            CSR_S2_POLE: pole_ff[1] <= csr_data;
            CSR_S3_MID:  mid_ff[2]  <= csr_data;
            CSR_S3_POLE: pole_ff[2] <= csr_data;
            CSR_RADIUS:  radius_ff  <= csr_data;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

endmodule
